/* rtl/core/ir_remote_frame_transmitter_top_macros.svh */
// Assertion macros for the IR frame transmitter checker.
// Used by ir_tx_checker.sv only; no other dependencies.
`ifndef IR_REMOTE_FRAME_TRANSMITTER_TOP_MACROS_SVH
`define IR_REMOTE_FRAME_TRANSMITTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define IR_TX_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IR_TX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ir_tx_pkg.sv */
// Shared types, register indexes and reset values for the IR frame transmitter.
// No dependencies.
`default_nettype none

package ir_tx_pkg;

    localparam int FRAME_BITS_DEF = 32;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PERIOD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_COMPARE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_US  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_US = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK_US     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_US    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE_US   = 4'd7;

    // Reset values (standard NEC timing)
    localparam logic [7:0]  RST_TICKS_PER_US    = 8'd84;
    localparam logic [15:0] RST_CARRIER_PERIOD  = 16'd4421;
    localparam logic [15:0] RST_CARRIER_COMPARE = 16'd2210;
    localparam logic [15:0] RST_LEADER_MARK_US  = 16'd9000;
    localparam logic [15:0] RST_LEADER_SPACE_US = 16'd4500;
    localparam logic [15:0] RST_BIT_MARK_US     = 16'd560;
    localparam logic [15:0] RST_ONE_SPACE_US    = 16'd1680;
    localparam logic [15:0] RST_ZERO_SPACE_US   = 16'd560;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4,
        PH_STOP_MARK  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0]  ticks_per_us;
        logic [15:0] carrier_period;
        logic [15:0] carrier_compare;
        logic [15:0] leader_mark_us;
        logic [15:0] leader_space_us;
        logic [15:0] bit_mark_us;
        logic [15:0] one_space_us;
        logic [15:0] zero_space_us;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] address;
        logic [7:0] command;
    } t_item;

    typedef struct packed {
        logic ir_out;
        logic envelope;
        logic busy_res;
        logic start_rejected;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/ir_tx_ifs.sv */
// Channel interfaces: item input, result output and register write.
// Depends on nothing; widths fixed by the field list.
`default_nettype none

interface ir_tx_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] address;
    logic [7:0] command;
    modport source (output valid, kind, address, command, input ready);
    modport sink   (input valid, kind, address, command, output ready);
endinterface

interface ir_tx_out_if;
    logic valid;
    logic ready;
    logic ir_out;
    logic envelope;
    logic busy_res;
    logic start_rejected;
    modport source (output valid, ir_out, envelope, busy_res, start_rejected, input ready);
    modport sink   (input valid, ir_out, envelope, busy_res, start_rejected, output ready);
    modport mon    (input valid, ready, ir_out, envelope, busy_res, start_rejected);
endinterface

interface ir_tx_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ir_tx_cfg_regs.sv */
// Configuration register file for the IR frame transmitter.
// Depends on ir_tx_pkg.
`default_nettype none

module ir_tx_cfg_regs (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_we,
    input  wire  [ir_tx_pkg::CFG_IDX_W-1:0]     i_index,
    input  wire  [ir_tx_pkg::CFG_DATA_W-1:0]    i_data,
    output ir_tx_pkg::t_cfg                     o_cfg
);
    import ir_tx_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_us    <= RST_TICKS_PER_US;
            r_cfg.carrier_period  <= RST_CARRIER_PERIOD;
            r_cfg.carrier_compare <= RST_CARRIER_COMPARE;
            r_cfg.leader_mark_us  <= RST_LEADER_MARK_US;
            r_cfg.leader_space_us <= RST_LEADER_SPACE_US;
            r_cfg.bit_mark_us     <= RST_BIT_MARK_US;
            r_cfg.one_space_us    <= RST_ONE_SPACE_US;
            r_cfg.zero_space_us   <= RST_ZERO_SPACE_US;
        end else if (i_we) begin
            // indexes past the list fall to the default and are dropped
            unique case (i_index)
                REG_TICKS_PER_US:    r_cfg.ticks_per_us    <= i_data[7:0];
                REG_CARRIER_PERIOD:  r_cfg.carrier_period  <= i_data;
                REG_CARRIER_COMPARE: r_cfg.carrier_compare <= i_data;
                REG_LEADER_MARK_US:  r_cfg.leader_mark_us  <= i_data;
                REG_LEADER_SPACE_US: r_cfg.leader_space_us <= i_data;
                REG_BIT_MARK_US:     r_cfg.bit_mark_us     <= i_data;
                REG_ONE_SPACE_US:    r_cfg.one_space_us    <= i_data;
                REG_ZERO_SPACE_US:   r_cfg.zero_space_us   <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/core/ir_tx_core.sv */
// Frame sequencer, prescaler and carrier counter: one item per firing.
// Depends on ir_tx_pkg.
`default_nettype none

module ir_tx_core #(
    parameter int FRAME_BITS = ir_tx_pkg::FRAME_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  ir_tx_pkg::t_item    i_item,
    input  ir_tx_pkg::t_cfg     i_cfg,
    output ir_tx_pkg::t_result  o_res
);
    import ir_tx_pkg::*;

    localparam logic [5:0] LAST_BIT = 6'(FRAME_BITS);

    t_phase      r_phase,  n_phase;
    logic [5:0]  r_bit,    n_bit;
    logic [31:0] r_frame,  n_frame;
    logic [15:0] r_seg,    n_seg;
    logic [7:0]  r_pre,    n_pre;
    logic [15:0] r_cc,     n_cc;
    logic        r_mark,   n_mark;
    logic        rejected;

    logic [7:0]  lim;
    logic [7:0]  pre_inc;
    logic [5:0]  bit_inc;

    assign lim     = (i_cfg.ticks_per_us == 8'd0) ? 8'd1 : i_cfg.ticks_per_us;
    assign pre_inc = r_pre + 8'd1;
    assign bit_inc = r_bit + 6'd1;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_frame  = r_frame;
        n_seg    = r_seg;
        n_pre    = r_pre;
        n_cc     = r_cc;
        n_mark   = r_mark;
        rejected = 1'b0;
        if (i_fire) begin
            if (i_item.kind == KIND_SEND) begin
                if (r_phase != PH_IDLE) begin
                    rejected = 1'b1;
                end else begin
                    n_frame = {~i_item.command, i_item.command,
                               ~i_item.address, i_item.address};
                    n_bit   = 6'd0;
                    n_pre   = 8'd0;
                    n_phase = PH_LEAD_MARK;
                    n_mark  = 1'b1;
                    n_seg   = i_cfg.leader_mark_us;
                end
            end else begin
                if (r_phase != PH_IDLE) begin
                    n_pre = pre_inc;
                    if (pre_inc >= lim) begin
                        n_pre = 8'd0;
                        if (r_seg <= 16'd1) begin
                            unique case (r_phase)
                                PH_LEAD_MARK: begin
                                    n_phase = PH_LEAD_SPACE;
                                    n_mark  = 1'b0;
                                    n_seg   = i_cfg.leader_space_us;
                                end
                                PH_LEAD_SPACE: begin
                                    n_bit   = 6'd0;
                                    n_phase = PH_BIT_MARK;
                                    n_mark  = 1'b1;
                                    n_seg   = i_cfg.bit_mark_us;
                                end
                                PH_BIT_MARK: begin
                                    n_phase = PH_BIT_SPACE;
                                    n_mark  = 1'b0;
                                    n_seg   = r_frame[r_bit[4:0]] ? i_cfg.one_space_us
                                                                  : i_cfg.zero_space_us;
                                end
                                PH_BIT_SPACE: begin
                                    n_bit   = bit_inc;
                                    n_phase = (bit_inc >= LAST_BIT) ? PH_STOP_MARK
                                                                    : PH_BIT_MARK;
                                    n_mark  = 1'b1;
                                    n_seg   = i_cfg.bit_mark_us;
                                end
                                default: begin
                                    n_phase = PH_IDLE;
                                    n_mark  = 1'b0;
                                    n_seg   = 16'd0;
                                end
                            endcase
                        end else begin
                            n_seg = r_seg - 16'd1;
                        end
                    end
                end
                // carrier follows the envelope as left by this tick
                if (n_mark) begin
                    n_cc = (r_cc >= i_cfg.carrier_period) ? 16'd0 : r_cc + 16'd1;
                end
            end
        end
    end

    // outputs: state after the item
    always_comb begin
        o_res.ir_out         = n_mark && (n_cc < i_cfg.carrier_compare);
        o_res.envelope       = n_mark;
        o_res.busy_res       = (n_phase != PH_IDLE);
        o_res.start_rejected = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= 6'd0;
            r_frame <= 32'd0;
            r_seg   <= 16'd0;
            r_pre   <= 8'd0;
            r_cc    <= 16'd0;
            r_mark  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_frame <= n_frame;
            r_seg   <= n_seg;
            r_pre   <= n_pre;
            r_cc    <= n_cc;
            r_mark  <= n_mark;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ir_remote_frame_transmitter_top.sv */
// Top level of the NEC-style IR frame transmitter: input and result stages.
// Depends on ir_tx_pkg, ir_tx_ifs, ir_tx_cfg_regs and ir_tx_core.
//
//  channel  | dir | beat content
//  ---------+-----+--------------------------------------------------
//  i_in     | in  | kind (tick / send), address, command
//  o_out    | out | ir_out, envelope, busy_res, start_rejected
//  i_cfg    | in  | register index (4 bits), write data (16 bits)
//
// One beat in per cycle while results are taken; each item yields one result
// beat (input register, then the sequencer step into the result register).
// The sequencer state loop is the single-cycle path. Reset (synchronous,
// active low) empties both stages, sends the sequencer idle and loads the
// NEC default timing. A stalled result holds one item in the input register
// before i_in.ready drops. Register writes are always taken, one per cycle.
`default_nettype none

module ir_remote_frame_transmitter_top #(
    parameter int FRAME_BITS = ir_tx_pkg::FRAME_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    ir_tx_in_if.sink       i_in,
    ir_tx_out_if.source    o_out,
    ir_tx_cfg_if.sink      i_cfg
);
    import ir_tx_pkg::*;

    // input stage
    logic    r_in_v;
    t_item   r_item;
    // result stage
    logic    r_out_v;
    t_result r_res;

    t_cfg    cfg;
    t_result core_res;
    logic    fire;
    logic    in_take;

    // the registered item steps when the result slot is free or draining
    assign fire    = r_in_v && (!r_out_v || o_out.ready);
    assign i_in.ready = !r_in_v || fire;
    assign in_take = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;

    ir_tx_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    ir_tx_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.ready) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.kind    <= i_in.kind;
            r_item.address <= i_in.address;
            r_item.command <= i_in.command;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (fire) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_out.valid          = r_out_v;
    assign o_out.ir_out         = r_res.ir_out;
    assign o_out.envelope       = r_res.envelope;
    assign o_out.busy_res       = r_res.busy_res;
    assign o_out.start_rejected = r_res.start_rejected;

endmodule

`default_nettype wire

/* rtl/core/ir_tx_checker.sv */
// Port-level checks on the result channel of the IR frame transmitter, and
// the bind that attaches them. Depends on the macro header.
`default_nettype none
`include "ir_remote_frame_transmitter_top_macros.svh"

module ir_tx_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire        i_ready,
    input  wire        i_ir_out,
    input  wire        i_envelope,
    input  wire        i_busy_res,
    input  wire        i_start_rejected
);

    // carrier only reaches the pin inside a mark
    `IR_TX_ASSERT_NOW(a_ir_needs_env, i_clk, i_rst_n, i_valid && i_ir_out, i_envelope, "ir_out high outside a mark")
    // a mark only happens within a frame
    `IR_TX_ASSERT_NOW(a_env_needs_busy, i_clk, i_rst_n, i_valid && i_envelope, i_busy_res, "envelope on while idle")
    // a rejected request leaves the frame running
    `IR_TX_ASSERT_NOW(a_rej_needs_busy, i_clk, i_rst_n, i_valid && i_start_rejected, i_busy_res, "request rejected while idle")
    // stalled result beat holds
    `IR_TX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable({i_ir_out, i_envelope, i_busy_res, i_start_rejected}), "stalled result changed")

endmodule

bind ir_remote_frame_transmitter_top ir_tx_checker u_ir_tx_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_ir_out         (o_out.ir_out),
    .i_envelope       (o_out.envelope),
    .i_busy_res       (o_out.busy_res),
    .i_start_rejected (o_out.start_rejected)
);

`default_nettype wire

/* test/ir_remote_frame_transmitter_top_test.sv */
// Self-checking bench for the IR frame transmitter top level.
// Needs ir_tx_pkg, the channel interfaces in ir_tx_ifs and the top module;
// expected output levels come from a frame tracker class held in this file.
`timescale 1ns / 1ps

module ir_remote_frame_transmitter_top_test;
    import ir_tx_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 5;
    localparam int PHASES      = 8;     // random phases, each with its own timing
    localparam int PHASE_ITEMS = 35;
    localparam int HOLD_CYCLES = 120;   // long result-side hold, fills the pipeline
    localparam int FINAL_TICKS = 600;   // full-scale timing, enough for two prescale wraps
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 500000;

    // ------------------------------------------------------------------
    // Frame tracker: own copy of the timing registers and the sequencer
    // state, advanced once per accepted beat. Each beat yields exactly one
    // expected set of output levels, queued in arrival order.
    // ------------------------------------------------------------------
    class ir_frame_tracker;
        t_cfg        timing;
        t_phase      seq_phase;
        logic [5:0]  bit_idx;
        logic [31:0] frame_word;
        logic [15:0] seg_left;
        logic [7:0]  prescale;
        logic [15:0] carrier_cnt;
        logic        mark;
        t_result     levels_due[$];
        int          errors;
        int          frames_started;
        int          refusals;
        int          beats_checked;

        function new();
            timing.ticks_per_us    = RST_TICKS_PER_US;
            timing.carrier_period  = RST_CARRIER_PERIOD;
            timing.carrier_compare = RST_CARRIER_COMPARE;
            timing.leader_mark_us  = RST_LEADER_MARK_US;
            timing.leader_space_us = RST_LEADER_SPACE_US;
            timing.bit_mark_us     = RST_BIT_MARK_US;
            timing.one_space_us    = RST_ONE_SPACE_US;
            timing.zero_space_us   = RST_ZERO_SPACE_US;
            seq_phase      = PH_IDLE;
            bit_idx        = '0;
            frame_word     = '0;
            seg_left       = '0;
            prescale       = '0;
            carrier_cnt    = '0;
            mark           = 1'b0;
            errors         = 0;
            frames_started = 0;
            refusals       = 0;
            beats_checked  = 0;
        endfunction

        function bit frame_active();
            return seq_phase != PH_IDLE;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TICKS_PER_US:    timing.ticks_per_us    = data[7:0];
                REG_CARRIER_PERIOD:  timing.carrier_period  = data;
                REG_CARRIER_COMPARE: timing.carrier_compare = data;
                REG_LEADER_MARK_US:  timing.leader_mark_us  = data;
                REG_LEADER_SPACE_US: timing.leader_space_us = data;
                REG_BIT_MARK_US:     timing.bit_mark_us     = data;
                REG_ONE_SPACE_US:    timing.one_space_us    = data;
                REG_ZERO_SPACE_US:   timing.zero_space_us   = data;
                default: ;
            endcase
        endfunction

        function void enter_segment(t_phase ph, logic on, logic [15:0] len);
            seq_phase = ph;
            mark      = on;
            seg_left  = len;
        endfunction

        // Segment expired: pick the next one from the current phase
        function void close_segment();
            case (seq_phase)
                PH_LEAD_MARK: enter_segment(PH_LEAD_SPACE, 1'b0, timing.leader_space_us);
                PH_LEAD_SPACE: begin
                    bit_idx = '0;
                    enter_segment(PH_BIT_MARK, 1'b1, timing.bit_mark_us);
                end
                PH_BIT_MARK: begin
                    if (frame_word[bit_idx[4:0]])
                        enter_segment(PH_BIT_SPACE, 1'b0, timing.one_space_us);
                    else
                        enter_segment(PH_BIT_SPACE, 1'b0, timing.zero_space_us);
                end
                PH_BIT_SPACE: begin
                    bit_idx = bit_idx + 6'd1;
                    if (bit_idx >= FRAME_BITS_DEF)
                        enter_segment(PH_STOP_MARK, 1'b1, timing.bit_mark_us);
                    else
                        enter_segment(PH_BIT_MARK, 1'b1, timing.bit_mark_us);
                end
                default: enter_segment(PH_IDLE, 1'b0, 16'd0);
            endcase
        endfunction

        function void take_item(t_item it);
            t_result    lv;
            logic [7:0] lim;
            lv.start_rejected = 1'b0;
            if (it.kind == KIND_SEND) begin
                if (seq_phase != PH_IDLE) begin
                    lv.start_rejected = 1'b1;
                    refusals++;
                end else begin
                    // address, ~address, command, ~command; byte 0 goes out first
                    frame_word = {~it.command, it.command, ~it.address, it.address};
                    bit_idx    = '0;
                    prescale   = '0;
                    frames_started++;
                    enter_segment(PH_LEAD_MARK, 1'b1, timing.leader_mark_us);
                end
            end else begin
                if (seq_phase != PH_IDLE) begin
                    lim      = (timing.ticks_per_us == 8'd0) ? 8'd1 : timing.ticks_per_us;
                    prescale = prescale + 8'd1;
                    if (prescale >= lim) begin
                        prescale = '0;
                        if (seg_left <= 16'd1)
                            close_segment();
                        else
                            seg_left = seg_left - 16'd1;
                    end
                end
                // carrier only runs under the envelope; holds its count otherwise
                if (mark)
                    carrier_cnt = (carrier_cnt >= timing.carrier_period) ? 16'd0
                                                                         : carrier_cnt + 16'd1;
            end
            lv.ir_out   = mark && (carrier_cnt < timing.carrier_compare);
            lv.envelope = mark;
            lv.busy_res = (seq_phase != PH_IDLE);
            levels_due.push_back(lv);
        endfunction

        function void field_check(string name, logic want, logic got);
            if (want !== got) begin
                errors++;
                $error("%s: expected %0b, got %0b", name, want, got);
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            beats_checked++;
            if (levels_due.size() == 0) begin
                errors++;
                $error("result beat with nothing outstanding");
                return;
            end
            want = levels_due.pop_front();
            field_check("ir_out", want.ir_out, got.ir_out);
            field_check("envelope", want.envelope, got.envelope);
            field_check("busy_res", want.busy_res, got.busy_res);
            field_check("start_rejected", want.start_rejected, got.start_rejected);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block under test
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    ir_tx_in_if  in_ch();
    ir_tx_out_if out_ch();
    ir_tx_cfg_if cfg_ch();

    ir_remote_frame_transmitter_top #(
        .FRAME_BITS (FRAME_BITS_DEF)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ir_frame_tracker frames = new();

    bit          gaps_on  = 1'b0;   // sender may leave gaps between beats
    bit          stall_on = 1'b0;   // receiver may drop ready in bursts
    bit          hold_req = 1'b0;   // one long receiver hold, cleared by the receiver
    int          items_sent = 0;
    int          settings_loaded = 0;
    int unsigned cycle_count = 0;
    t_result     seen_beat;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: ready driven at the falling edge. Ready drops in random
    // bursts when stalling is on; a requested hold is counted here.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen_beat.ir_out         = out_ch.ir_out;
            seen_beat.envelope       = out_ch.envelope;
            seen_beat.busy_res       = out_ch.busy_res;
            seen_beat.start_rejected = out_ch.start_rejected;
            frames.check_beat(seen_beat);
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends on a falling edge.
    // ------------------------------------------------------------------

    // One input beat; valid stays high on return so back-to-back beats
    // need no extra assignment in the same step.
    task automatic offer(input t_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= it.kind;
        in_ch.address <= it.address;
        in_ch.command <= it.command;
        do @(posedge i_clk); while (!in_ch.ready);
        frames.take_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Tick with random payload: address and command are don't-care here
    task automatic offer_tick();
        t_item it;
        it.kind    = KIND_TICK;
        it.address = 8'($urandom_range(0, 255));
        it.command = 8'($urandom_range(0, 255));
        offer(it);
    endtask

    task automatic offer_send(input logic [7:0] addr, input logic [7:0] cmd);
        t_item it;
        it.kind    = KIND_SEND;
        it.address = addr;
        it.command = cmd;
        offer(it);
    endtask

    // Mostly well-formed traffic: a request when idle, then ticks to run
    // the frame out, with the odd request thrown in mid-frame.
    task automatic offer_random();
        t_item it;
        it.address = 8'($urandom_range(0, 255));
        it.command = 8'($urandom_range(0, 255));
        if (frames.frame_active())
            it.kind = ($urandom_range(0, 19) == 0) ? KIND_SEND : KIND_TICK;
        else
            it.kind = ($urandom_range(0, 2) == 0) ? KIND_TICK : KIND_SEND;
        offer(it);
    endtask

    // Stop offering and wait for every outstanding result beat
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (frames.levels_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write all eight registers plus one stray index past the list.
    // Upper byte of the ticks-per-us write is junk and must be dropped.
    task automatic load_timing(input t_cfg c);
        logic [CFG_IDX_W-1:0]  idx_list [0:8];
        logic [CFG_DATA_W-1:0] data_list[0:8];
        idx_list[0]  = REG_TICKS_PER_US;
        data_list[0] = {8'($urandom_range(0, 255)), c.ticks_per_us};
        idx_list[1]  = REG_CARRIER_PERIOD;
        data_list[1] = c.carrier_period;
        idx_list[2]  = REG_CARRIER_COMPARE;
        data_list[2] = c.carrier_compare;
        idx_list[3]  = REG_LEADER_MARK_US;
        data_list[3] = c.leader_mark_us;
        idx_list[4]  = REG_LEADER_SPACE_US;
        data_list[4] = c.leader_space_us;
        idx_list[5]  = REG_BIT_MARK_US;
        data_list[5] = c.bit_mark_us;
        idx_list[6]  = REG_ONE_SPACE_US;
        data_list[6] = c.one_space_us;
        idx_list[7]  = REG_ZERO_SPACE_US;
        data_list[7] = c.zero_space_us;
        idx_list[8]  = CFG_IDX_W'(REG_ZERO_SPACE_US + 1 + $urandom_range(0, 7));
        data_list[8] = CFG_DATA_W'($urandom_range(0, 65535));
        for (int i = 0; i < 9; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx_list[i];
            cfg_ch.data  <= data_list[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            frames.write_reg(idx_list[i], data_list[i]);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        settings_loaded++;
    endtask

    // Short segments and a fast prescale so frames finish quickly; some
    // phases force the carrier and prescale corner settings.
    function automatic t_cfg timing_for(int ph);
        t_cfg c;
        c.ticks_per_us    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 3)) : 8'd1;
        c.carrier_period  = 16'($urandom_range(0, 5));
        c.carrier_compare = 16'($urandom_range(0, 6));
        c.leader_mark_us  = 16'($urandom_range(0, 3));
        c.leader_space_us = 16'($urandom_range(0, 3));
        c.bit_mark_us     = 16'($urandom_range(0, 2));
        c.one_space_us    = 16'($urandom_range(0, 3));
        c.zero_space_us   = 16'($urandom_range(0, 2));
        case (ph)
            0: c.carrier_period = 16'd0;            // counter pinned at zero
            1: begin                                // carrier never low
                c.carrier_period  = 16'hFFFF;
                c.carrier_compare = 16'hFFFF;
            end
            2: c.ticks_per_us = 8'd0;               // prescale of zero acts as one
            3: begin                                // wide random carrier values
                c.carrier_period  = 16'($urandom_range(0, 65535));
                c.carrier_compare = 16'($urandom_range(0, 65535));
            end
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_cfg c;

        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_TICK;
        in_ch.address = '0;
        in_ch.command = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        i_rst_n       = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle ticks under the reset timing: nothing should move
        offer_tick();
        offer_tick();
        quiesce();

        // Directed timing: zero-length leader space, one-microsecond marks,
        // prescale of two, a carrier that wraps every third tick
        c.ticks_per_us    = 8'd2;
        c.carrier_period  = 16'd2;
        c.carrier_compare = 16'd1;
        c.leader_mark_us  = 16'd1;
        c.leader_space_us = 16'd0;
        c.bit_mark_us     = 16'd1;
        c.one_space_us    = 16'd2;
        c.zero_space_us   = 16'd1;
        load_timing(c);

        // Directed beats: field extremes, accepted request, refused requests
        offer_tick();
        offer_send(8'h00, 8'hFF);
        offer_send(8'hFF, 8'h00);
        offer_send(8'hAA, 8'h55);
        repeat (14) offer_tick();
        offer_send(8'h55, 8'hAA);

        // Random phases; each starts with the pipeline drained, usually
        // with a frame still in flight so new timing lands mid-frame
        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            gaps_on  = (ph != 5);
            stall_on = (ph != 5);
            load_timing(timing_for(ph));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == 20)
                    hold_req = 1'b1;    // receiver holds while we keep pushing
                if (ph == 4 && n == 20)
                    quiesce();          // sender pauses until all results are back
                offer_random();
            end
        end

        // No idling from here on
        gaps_on  = 1'b0;
        stall_on = 1'b0;

        // Run out the last frame so the full-scale one starts from idle
        while (frames.frame_active())
            offer_tick();
        quiesce();

        // Final part: full-scale timing on every register but the random carrier compare
        c.ticks_per_us    = 8'hFF;
        c.carrier_period  = 16'hFFFF;
        c.carrier_compare = 16'($urandom_range(0, 65535));
        c.leader_mark_us  = 16'hFFFF;
        c.leader_space_us = 16'hFFFF;
        c.bit_mark_us     = 16'hFFFF;
        c.one_space_us    = 16'hFFFF;
        c.zero_space_us   = 16'hFFFF;
        load_timing(c);
        offer_send(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        offer_send(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        repeat (FINAL_TICKS) offer_tick();

        // Drain, then let the pipeline idle so any extra beat shows
        in_ch.valid <= 1'b0;
        while (frames.levels_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d input beats over %0d timing settings, %0d result beats checked.",
                 items_sent, settings_loaded, frames.beats_checked);
        $display("Frames started: %0d, requests refused while busy: %0d.",
                 frames.frames_started, frames.refusals);
        if (frames.errors == 0 && frames.levels_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
